FILE: rtl/ccfd_pkg.sv
// ----------------------------------------------------------------------------
// ccfd_pkg: shared types and helpers of the COBS/CRC frame decoder
// Item structs, error codes, queue sizing and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package ccfd_pkg;

  // Number of entries in the queue between the front and back parts.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam logic [1:0] CfgMinLen  = 2'd0;
  localparam logic [1:0] CfgMaxLen  = 2'd1;
  localparam logic [1:0] CfgCrcPoly = 2'd2;
  localparam logic [1:0] CfgCrcInit = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  MinLenReset  = 8'd5;
  localparam logic [7:0]  MaxLenReset  = 8'd255;
  localparam logic [15:0] CrcPolyReset = 16'h1021;
  localparam logic [15:0] CrcInitReset = 16'hFFFF;

  // Error codes, lower nonzero code ranks higher.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_RANGE   = 3'd1,
    ERR_LENBYTE = 3'd2,
    ERR_POINTER = 3'd3,
    ERR_CRC     = 3'd4
  } err_kind_e;

  // Input item of the frame byte stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       first_of_frame;
  } in_item_t;

  // Result item of the decoded byte stream.
  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       last_of_frame;
    logic       frame_good;
    logic [2:0] error_kind;
  } out_item_t;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] dec;
    logic       first;
    logic       idle;
    logic       last;
    logic       crc_en;
    logic       hi_en;
    logic       too_short;
    err_kind_e  err;
  } q_item_t;

  // Queue status seen by both parts.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Keep the higher-ranked of the pending error and a new one.
  function automatic err_kind_e merge_err(err_kind_e pend, err_kind_e kind);
    err_kind_e res;
    res = pend;
    if (kind != ERR_NONE && (pend == ERR_NONE || kind < pend)) begin
      res = kind;
    end
    return res;
  endfunction

  // MSB-first CRC-16 update over one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/ccfd_in_if.sv
// ----------------------------------------------------------------------------
// ccfd_in_if: frame byte input channel
// Valid/ready channel that carries one raw frame byte per transfer.
// ----------------------------------------------------------------------------
interface ccfd_in_if;
  import ccfd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/ccfd_out_if.sv
// ----------------------------------------------------------------------------
// ccfd_out_if: decoded byte output channel
// Valid/ready channel that carries one decoded byte and frame status per transfer.
// ----------------------------------------------------------------------------
interface ccfd_out_if;
  import ccfd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/ccfd_front.sv
// ----------------------------------------------------------------------------
// ccfd_front: byte classifier
// Tracks the byte position and the COBS pointer chain, zeroes pointer bytes
// and flags the length, pointer and CRC-window conditions of each byte.
// ----------------------------------------------------------------------------
module ccfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          min_len_i,
  input  logic [7:0]          max_len_i,
  ccfd_in_if.sink             in_if,
  input  ccfd_pkg::q_status_t q_status_i,
  output logic                push_o,
  output ccfd_pkg::q_item_t   push_item_o
);
  import ccfd_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] nptr_q, nptr_d;
  logic [7:0] len_q, len_d;

  logic       first;
  logic [7:0] data;
  logic [7:0] p_eff;
  logic [7:0] len_eff;
  logic [7:0] nptr_eff;
  logic       idle;
  logic       hit;
  logic       range_err;
  logic       lenbyte_err;
  logic       ptr_err;
  logic [8:0] p_ext;
  logic [8:0] len_ext;
  err_kind_e  err;

  // Accept whenever the queue has room.
  assign in_if.ready = !q_status_i.full;
  assign push_o      = in_if.valid && in_if.ready;

  assign first = in_if.payload.first_of_frame;
  assign data  = in_if.payload.data_byte;

  // A frame start overrides whatever frame was running.
  assign p_eff    = first ? 8'd0 : pos_q;
  assign len_eff  = first ? in_if.payload.frame_length : len_q;
  assign nptr_eff = first ? 8'd0 : nptr_q;
  assign idle     = !first && (pos_q >= len_q);
  assign p_ext    = {1'b0, p_eff};
  assign len_ext  = {1'b0, len_eff};

  // Per-byte checks.
  assign hit         = (p_eff == nptr_eff);
  assign range_err   = first && ((len_eff < min_len_i) || (len_eff > max_len_i));
  assign lenbyte_err = (p_eff == 8'd1) && (data != (len_eff - 8'd1));
  assign ptr_err     = hit && (({1'b0, data} + {1'b0, nptr_eff}) > len_ext);

  // Highest-ranked error found on this byte.
  always_comb begin
    err = ERR_NONE;
    if (ptr_err) begin
      err = ERR_POINTER;
    end
    if (lenbyte_err) begin
      err = ERR_LENBYTE;
    end
    if (range_err) begin
      err = ERR_RANGE;
    end
  end

  // Classified item for the back part.
  always_comb begin
    push_item_o.dec       = (hit && !idle) ? 8'd0 : data;
    push_item_o.first     = first;
    push_item_o.idle      = idle;
    push_item_o.last      = (p_ext + 9'd1) >= len_ext;
    push_item_o.crc_en    = (p_eff != 8'd0) && ((p_ext + 9'd3) <= len_ext);
    push_item_o.hi_en     = (p_ext + 9'd2) == len_ext;
    push_item_o.too_short = len_eff < 8'd3;
    push_item_o.err       = err;
  end

  // Position tracking, held on idle bytes.
  always_comb begin
    pos_d  = pos_q;
    nptr_d = nptr_q;
    len_d  = len_q;
    if (push_o && !idle) begin
      pos_d  = p_eff + 8'd1;
      nptr_d = hit ? (nptr_eff + data) : nptr_eff;
      len_d  = len_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nptr_q <= '0;
      len_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      nptr_q <= nptr_d;
      len_q  <= len_d;
    end
  end

endmodule

FILE: rtl/ccfd_queue.sv
// ----------------------------------------------------------------------------
// ccfd_queue: queue between the front and back parts
// Small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module ccfd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ccfd_pkg::q_item_t   push_item_i,
  input  logic                pop_i,
  output ccfd_pkg::q_item_t   pop_item_o,
  output ccfd_pkg::q_status_t status_o
);
  import ccfd_pkg::*;

  q_item_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign status_o.full      = (cnt_q == QCntW'(QDepth));
  assign status_o.not_empty = (cnt_q != '0);
  assign pop_item_o         = mem_q[rd_q];

  // Pointer wrap at the queue depth.
  function automatic logic [QPtrW-1:0] next_ptr(logic [QPtrW-1:0] ptr);
    logic [QPtrW-1:0] res;
    res = (ptr == QPtrW'(QDepth - 1)) ? '0 : ptr + 1'b1;
    return res;
  endfunction

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.not_empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue fill count out of range");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill count missed a write");
`endif

endmodule

FILE: rtl/ccfd_back.sv
// ----------------------------------------------------------------------------
// ccfd_back: CRC and status engine
// Runs the CRC over the frame body, keeps the pending error and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module ccfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         crc_poly_i,
  input  logic [15:0]         crc_init_i,
  input  ccfd_pkg::q_status_t q_status_i,
  input  ccfd_pkg::q_item_t   q_item_i,
  output logic                pop_o,
  ccfd_out_if.source          out_if
);
  import ccfd_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  hi_q, hi_d;
  err_kind_e   pend_q, pend_d;
  logic        out_valid_q;
  out_item_t   out_item_q;
  out_item_t   result;

  logic [15:0] crc_base;
  logic [7:0]  hi_base;
  err_kind_e   pend_base;
  err_kind_e   pend_byte;
  err_kind_e   pend_fin;

  // Take an entry when the output register is free or being emptied.
  assign pop_o = q_status_i.not_empty && (!out_valid_q || out_if.ready);

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_item_q;

  // Frame start reloads the running state.
  assign crc_base  = q_item_i.first ? crc_init_i : crc_q;
  assign hi_base   = q_item_i.first ? 8'd0 : hi_q;
  assign pend_base = q_item_i.first ? ERR_NONE : pend_q;
  assign pend_byte = merge_err(pend_base, q_item_i.err);

  // Running CRC, trailer capture and final checks.
  always_comb begin
    crc_d    = q_item_i.crc_en ? crc_byte(crc_base, q_item_i.dec, crc_poly_i) : crc_base;
    hi_d     = q_item_i.hi_en ? q_item_i.dec : hi_base;
    pend_fin = pend_byte;
    if (q_item_i.last) begin
      if (q_item_i.too_short) begin
        pend_fin = merge_err(pend_byte, ERR_LENBYTE);
      end else if ({hi_base, q_item_i.dec} != crc_d) begin
        pend_fin = merge_err(pend_byte, ERR_CRC);
      end
    end
    pend_d = pend_fin;
  end

  // Result item; bytes outside a frame pass through untouched.
  always_comb begin
    result.decoded_byte  = q_item_i.dec;
    result.last_of_frame = 1'b0;
    result.frame_good    = 1'b0;
    result.error_kind    = ERR_NONE;
    if (!q_item_i.idle && q_item_i.last) begin
      result.last_of_frame = 1'b1;
      result.frame_good    = (pend_fin == ERR_NONE);
      result.error_kind    = pend_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      hi_q        <= '0;
      pend_q      <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && !q_item_i.idle) begin
        crc_q  <= crc_d;
        hi_q   <= hi_d;
        pend_q <= pend_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_item_q <= result;
    end
  end

`ifndef SYNTH
  a_good_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.frame_good) |->
      (out_item_q.last_of_frame && out_item_q.error_kind == ERR_NONE))
    else $error("good frame reported with an error code");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.last_of_frame) |->
      (!out_item_q.frame_good && out_item_q.error_kind == ERR_NONE))
    else $error("frame status on a byte that is not the last");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |-> !pop_o)
    else $error("result register overwritten while stalled");
`endif

endmodule

FILE: rtl/cobs_crc_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// cobs_crc_frame_decoder_core: COBS frame decoder with CRC-16 check
// Decodes a COBS byte stream and reports per-frame length, pointer and CRC
// status with the last byte of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one raw frame byte per transfer with the frame length and a
//   first-of-frame mark; out_if returns exactly one decoded byte per input
//   transfer, in order. Pointer bytes come out as zero. The last byte of a
//   frame carries frame_good and error_kind; bytes outside a frame pass through.
//   The cfg port writes min/max length, CRC polynomial and CRC start value;
//   write it only while no byte is in flight.
//   From an input transfer to a valid result, each byte passes through the
//   classifier queue and then the output register.
//   Throughput is one byte per cycle while the receiver takes results; the
//   CRC update of one byte is combinational logic in the back part.
//   Reset empties the queue and the output register and restores the
//   register defaults (5, 255, 0x1021, 0xFFFF). When the receiver stalls, the
//   two-entry queue fills and in_if.ready drops until results drain.
// ----------------------------------------------------------------------------
module cobs_crc_frame_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccfd_in_if.sink     in_if,
  ccfd_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import ccfd_pkg::*;

  logic [7:0]  min_len_q;
  logic [7:0]  max_len_q;
  logic [15:0] crc_poly_q;
  logic [15:0] crc_init_q;

  logic        push;
  logic        pop;
  q_item_t     push_item;
  q_item_t     pop_item;
  q_status_t   q_status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= MinLenReset;
      max_len_q  <= MaxLenReset;
      crc_poly_q <= CrcPolyReset;
      crc_init_q <= CrcInitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinLen:  min_len_q  <= cfg_data_i[7:0];
        CfgMaxLen:  max_len_q  <= cfg_data_i[7:0];
        CfgCrcPoly: crc_poly_q <= cfg_data_i;
        CfgCrcInit: crc_init_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front part: classify incoming bytes.
  ccfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_len_i   (min_len_q),
    .max_len_i   (max_len_q),
    .in_if       (in_if),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue between the two parts.
  ccfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  // Back part: CRC, status and result register.
  ccfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .crc_poly_i (crc_poly_q),
    .crc_init_i (crc_init_q),
    .q_status_i (q_status),
    .q_item_i   (pop_item),
    .pop_o      (pop),
    .out_if     (out_if)
  );

endmodule

FILE: tb/sv/cobs_crc_frame_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_decoder_core_test: self-checking bench of the COBS/CRC decoder
// Sends raw frame bytes over the input channel, predicts every decoded byte
// and its frame status, and compares each output transfer with the oldest
// prediction. Directed frames come first, then random well-formed and broken
// frames under several register settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module cobs_crc_frame_decoder_core_test;
  import ccfd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned ReportLimit = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  ccfd_in_if  in_ch ();
  ccfd_out_if out_ch ();

  cobs_crc_frame_decoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register copies used for prediction.
  logic [7:0]  cfg_min_len;
  logic [7:0]  cfg_max_len;
  logic [15:0] cfg_poly;
  logic [15:0] cfg_init;

  // Frame tracking state of the predictor.
  logic [7:0]  fr_pos;
  logic [7:0]  fr_nptr;
  logic [7:0]  fr_len;
  logic [7:0]  fr_crc_hi;
  logic [15:0] fr_crc;
  err_kind_e   fr_err;

  out_item_t   decoded_q[$];
  logic [7:0]  frame_buf[$];

  bit          failed;
  int unsigned report_count;
  int unsigned cycle_count;
  int          tx_gap_pct;
  int          rx_stall_pct;
  int          hold_left;
  int          stall_left;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Gap length: mostly short, sometimes long.
  function automatic int idle_len();
    int n;
    if ($urandom_range(9) < 8) begin
      n = $urandom_range(3, 1);
    end else begin
      n = $urandom_range(30, 8);
    end
    return n;
  endfunction

  // MSB-first CRC-16 over one byte with the current polynomial.
  function automatic logic [15:0] crc16_shift(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    int          i;
    r = acc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ cfg_poly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Keep the highest-ranked error; a lower nonzero code ranks higher.
  function automatic err_kind_e ranked(err_kind_e cur, err_kind_e kind);
    err_kind_e r;
    r = cur;
    if (kind != ERR_NONE && (cur == ERR_NONE || kind < cur)) begin
      r = kind;
    end
    return r;
  endfunction

  // Predict the result of one accepted byte and advance the frame state.
  function automatic out_item_t decode_byte(in_item_t it);
    out_item_t   r;
    int          p;
    int          ln;
    logic [7:0]  dec;
    r = '0;
    if (it.first_of_frame) begin
      fr_len    = it.frame_length;
      fr_pos    = 8'd0;
      fr_nptr   = 8'd0;
      fr_crc    = cfg_init;
      fr_crc_hi = 8'd0;
      fr_err    = ERR_NONE;
      if (it.frame_length < cfg_min_len || it.frame_length > cfg_max_len) begin
        fr_err = ranked(fr_err, ERR_RANGE);
      end
    end else if (fr_pos >= fr_len) begin
      // Outside a frame the byte passes through with no status.
      r.decoded_byte = it.data_byte;
      return r;
    end

    p   = int'(fr_pos);
    ln  = int'(fr_len);
    dec = it.data_byte;

    // A pointer byte decodes to zero and names the next pointer position.
    if (p == int'(fr_nptr)) begin
      if (int'(it.data_byte) > ln - int'(fr_nptr)) begin
        fr_err = ranked(fr_err, ERR_POINTER);
      end
      fr_nptr = fr_nptr + it.data_byte;
      dec = 8'd0;
    end

    if (p == 1 && int'(it.data_byte) != ln - 1) begin
      fr_err = ranked(fr_err, ERR_LENBYTE);
    end
    if (p >= 1 && p + 3 <= ln) begin
      fr_crc = crc16_shift(fr_crc, dec);
    end
    if (p + 2 == ln) begin
      fr_crc_hi = dec;
    end
    fr_pos = 8'(p + 1);

    r.decoded_byte = dec;
    if (p + 1 >= ln) begin
      if (ln < 3) begin
        fr_err = ranked(fr_err, ERR_LENBYTE);
      end else if ({fr_crc_hi, dec} != fr_crc) begin
        fr_err = ranked(fr_err, ERR_CRC);
      end
      r.last_of_frame = 1'b1;
      r.frame_good    = (fr_err == ERR_NONE);
      r.error_kind    = fr_err;
    end
    return r;
  endfunction

  // Offer one byte, wait for its transfer and record its prediction.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    // Ready is stable at the falling edge, so this decides the next rising edge.
    @(negedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    decoded_q.push_back(decode_byte(it));
    @(posedge clk_i);
  endtask

  // Send the first count bytes of frame_buf as one frame.
  task automatic send_frame(input int len_field, input int count);
    in_item_t it;
    int       i;
    for (i = 0; i < count; i++) begin
      it.data_byte      = frame_buf[i];
      it.first_of_frame = (i == 0);
      it.frame_length   = (i == 0) ? 8'(len_field) : 8'($urandom_range(255));
      send_item(it);
    end
  endtask

  // Build a well-formed frame of len bytes (len >= 4) into frame_buf.
  task automatic build_good_frame(input int len);
    bit          is_ptr [0:255];
    int          q;
    int          step;
    int          room;
    int          i;
    bit          done;
    logic [15:0] c;
    frame_buf.delete();
    for (i = 0; i < 256; i++) begin
      is_ptr[i] = 1'b0;
    end
    for (i = 0; i < len; i++) begin
      frame_buf.push_back(8'd0);
    end

    // Pointer chain stays clear of the trailer; the last one ends the chain
    // either with a zero pointer or one that points exactly at the frame end.
    q = 0;
    done = 1'b0;
    while (!done) begin
      room = len - 3 - q;
      if (room >= 1 && $urandom_range(3) != 0) begin
        if ($urandom_range(1) != 0) begin
          step = $urandom_range((room < 4) ? room : 4, 1);
        end else begin
          step = $urandom_range(room, 1);
        end
        is_ptr[q] = 1'b1;
        if (q == 0 && step == 1) begin
          // Byte 1 becomes a pointer and must still carry length-1.
          frame_buf[0] = 8'd1;
          frame_buf[1] = 8'(len - 1);
          is_ptr[1] = 1'b1;
          done = 1'b1;
        end else begin
          frame_buf[q] = 8'(step);
          q = q + step;
        end
      end else begin
        is_ptr[q] = 1'b1;
        frame_buf[q] = ($urandom_range(1) != 0) ? 8'd0 : 8'(len - q);
        done = 1'b1;
      end
    end

    for (i = 1; i <= len - 3; i++) begin
      if (!is_ptr[i]) begin
        if (i == 1) begin
          frame_buf[i] = 8'(len - 1);
        end else if ($urandom_range(4) == 0) begin
          frame_buf[i] = 8'd0;
        end else begin
          frame_buf[i] = 8'($urandom_range(255));
        end
      end
    end

    // Big-endian CRC trailer over the decoded body.
    c = cfg_init;
    for (i = 1; i <= len - 3; i++) begin
      c = crc16_shift(c, is_ptr[i] ? 8'd0 : frame_buf[i]);
    end
    frame_buf[len - 2] = c[15:8];
    frame_buf[len - 1] = c[7:0];
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all four registers while the block is idle.
  task automatic write_regs(input logic [7:0] min_len, input logic [7:0] max_len,
                            input logic [15:0] poly, input logic [15:0] init);
    wait_idle();
    // The upper byte of the length registers is ignored, so it is random.
    write_reg(CfgMinLen, {8'($urandom_range(255)), min_len});
    write_reg(CfgMaxLen, {8'($urandom_range(255)), max_len});
    write_reg(CfgCrcPoly, poly);
    write_reg(CfgCrcInit, init);
    cfg_we_i    <= 1'b0;
    cfg_min_len = min_len;
    cfg_max_len = max_len;
    cfg_poly    = poly;
    cfg_init    = init;
    @(posedge clk_i);
  endtask

  // Bytes with no frame active pass through unchanged.
  task automatic test_idle_bytes();
    send_item(in_item_t'{8'hA5, 8'h00, 1'b0});
    send_item(in_item_t'{8'h5A, 8'hFF, 1'b0});
  endtask

  // Lengths zero and one end on their first byte.
  task automatic test_short_frames();
    send_item(in_item_t'{8'hFF, 8'h00, 1'b1});
    send_item(in_item_t'{8'h00, 8'h01, 1'b1});
  endtask

  task automatic test_good_frame();
    build_good_frame(5);
    send_frame(5, 5);
  endtask

  // Several errors in one frame: the highest rank is reported.
  task automatic test_error_ranking();
    build_good_frame(5);
    frame_buf[0] = 8'hFF;
    frame_buf[1] = frame_buf[1] ^ 8'h80;
    send_frame(5, 5);
    // Zero pointer at the start, with a damaged trailer.
    build_good_frame(6);
    frame_buf[0] = 8'h00;
    frame_buf[5] = frame_buf[5] ^ 8'hFF;
    send_frame(6, 6);
  endtask

  // A new first byte drops the frame still in progress.
  task automatic test_restart();
    build_good_frame(6);
    send_frame(6, 2);
    build_good_frame(5);
    send_frame(5, 5);
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    int saved_gap;
    saved_gap  = tx_gap_pct;
    tx_gap_pct = 0;
    hold_left  = 120;
    build_good_frame(20);
    send_frame(20, 20);
    build_good_frame(20);
    send_frame(20, 20);
    tx_gap_pct = saved_gap;
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise.
  task automatic test_random_traffic(input int budget);
    int sent;
    int kind;
    int len;
    int lo;
    int hi;
    int cnt;
    int i;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(99);
      lo = (cfg_min_len > 4) ? int'(cfg_min_len) : 4;
      hi = int'(cfg_max_len);
      if (lo > hi) begin
        len = $urandom_range(20, 4);
      end else if ($urandom_range(99) < 85) begin
        len = $urandom_range((hi < lo + 16) ? hi : lo + 16, lo);
      end else begin
        len = $urandom_range(hi, lo);
      end

      if (kind < 70) begin
        // Well-formed frame, sometimes with one flipped bit.
        build_good_frame(len);
        if ($urandom_range(3) == 0) begin
          i = $urandom_range(len - 1);
          frame_buf[i] = frame_buf[i] ^ 8'(1 << $urandom_range(7));
        end
        send_frame(len, len);
        sent += len;
      end else if (kind < 78) begin
        // Any length with random content.
        len = ($urandom_range(1) != 0) ? $urandom_range(12) : $urandom_range(255);
        cnt = (len == 0) ? 1 : len;
        frame_buf.delete();
        for (i = 0; i < cnt; i++) begin
          frame_buf.push_back(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
        end
        send_frame(len, cnt);
        sent += cnt;
      end else if (kind < 86) begin
        // Cut off by the next frame.
        build_good_frame(len);
        cnt = $urandom_range(len - 1, 1);
        send_frame(len, cnt);
        sent += cnt;
      end else if (kind < 93) begin
        // Stray bytes between frames.
        cnt = $urandom_range(4, 1);
        for (i = 0; i < cnt; i++) begin
          send_item(in_item_t'{8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0});
        end
      end else begin
        // Length field that disagrees with the frame sent.
        build_good_frame(len);
        cnt = len + $urandom_range(4) - 2;
        if (cnt < 0) cnt = 0;
        if (cnt > 255) cnt = 255;
        send_frame(cnt, len);
        sent += len;
      end
    end
  endtask

  // Random traffic under several register settings, extremes included.
  task automatic test_config_sweep();
    test_random_traffic(300);

    write_regs(8'd3, 8'd255, 16'h8005, 16'h0000);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    test_random_traffic(300);

    write_regs(8'd3, 8'd3, 16'h0000, 16'hFFFF);
    tx_gap_pct   = 30;
    rx_stall_pct = 10;
    test_random_traffic(150);

    write_regs(8'd255, 8'd255, 16'hFFFF, 16'h0000);
    tx_gap_pct   = 10;
    rx_stall_pct = 30;
    test_random_traffic(300);

    write_regs(8'd200, 8'd10, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
    test_random_traffic(150);

    write_regs(8'd4, 8'd40, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
    tx_gap_pct   = 40;
    rx_stall_pct = 40;
    test_random_traffic(450);
  endtask

  // Receiver: random stalls, plus a long hold when a test asks for one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
          stall_left = idle_len();
        end
      end
    end
  end

  // Compare every output transfer with the oldest prediction.
  always @(negedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        failed = 1'b1;
        if (report_count < ReportLimit) begin
          $display("%0t: unexpected transfer, decoded_byte %02h", $time,
                   out_ch.payload.decoded_byte);
        end
        report_count++;
      end else begin
        exp_item = decoded_q.pop_front();
        if (out_ch.payload.decoded_byte !== exp_item.decoded_byte ||
            out_ch.payload.last_of_frame !== exp_item.last_of_frame ||
            out_ch.payload.frame_good !== exp_item.frame_good ||
            out_ch.payload.error_kind !== exp_item.error_kind) begin
          failed = 1'b1;
          if (report_count < ReportLimit) begin
            if (out_ch.payload.decoded_byte !== exp_item.decoded_byte)
              $display("%0t: decoded_byte expected %02h actual %02h", $time,
                       exp_item.decoded_byte, out_ch.payload.decoded_byte);
            if (out_ch.payload.last_of_frame !== exp_item.last_of_frame)
              $display("%0t: last_of_frame expected %0b actual %0b", $time,
                       exp_item.last_of_frame, out_ch.payload.last_of_frame);
            if (out_ch.payload.frame_good !== exp_item.frame_good)
              $display("%0t: frame_good expected %0b actual %0b", $time,
                       exp_item.frame_good, out_ch.payload.frame_good);
            if (out_ch.payload.error_kind !== exp_item.error_kind)
              $display("%0t: error_kind expected %0d actual %0d", $time,
                       exp_item.error_kind, out_ch.payload.error_kind);
          end
          report_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgMinLen;
    cfg_data_i    = 16'h0000;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    failed        = 1'b0;
    report_count  = 0;
    cycle_count   = 0;
    hold_left     = 0;
    stall_left    = 0;
    tx_gap_pct    = 20;
    rx_stall_pct  = 20;
    cfg_min_len   = MinLenReset;
    cfg_max_len   = MaxLenReset;
    cfg_poly      = CrcPolyReset;
    cfg_init      = CrcInitReset;
    fr_pos        = 8'd0;
    fr_nptr       = 8'd0;
    fr_len        = 8'd0;
    fr_crc_hi     = 8'd0;
    fr_crc        = 16'h0000;
    fr_err        = ERR_NONE;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_bytes();
    test_short_frames();
    test_good_frame();
    test_error_ranking();
    test_restart();
    test_backpressure();
    test_config_sweep();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
